/* hdl/uart_memory_debug_bridge_macros.svh */
// assertion helpers for the serial debug bridge
// expects signals named clock and reset in the module that uses them
`ifndef UART_MEMORY_DEBUG_BRIDGE_MACROS_SVH
`define UART_MEMORY_DEBUG_BRIDGE_MACROS_SVH

// condition holds at every edge outside reset
`define UMDB_ASSERT_ALWAYS(name, cond, msg) \
   name: assert property (@(posedge clock) disable iff (reset) (cond)) else $error(msg);

// consequent holds in the same cycle as the antecedent
`define UMDB_ASSERT_IMPLY(name, ante, cons, msg) \
   name: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// consequent holds in the cycle after the antecedent
`define UMDB_ASSERT_NEXT(name, ante, cons, msg) \
   name: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

/* hdl/umdb_pkg.sv */
// types, codes and helpers shared by the serial debug bridge
// no dependencies
package umdb_pkg;

   parameter logic [63:0] MAGIC_WORD = 64'h474f_4245_4152_5321;

   parameter logic [7:0] CHAR_A = 8'h41;
   parameter logic [7:0] CHAR_R = 8'h52;
   parameter logic [7:0] CHAR_W = 8'h57;
   parameter logic [7:0] CHAR_J = 8'h4a;
   parameter logic [7:0] CHAR_G = 8'h47;
   parameter logic [7:0] CHAR_Y = 8'h59;
   parameter logic [7:0] CHAR_N = 8'h4e;

   parameter logic [3:0] SKIP_BYTES = 4'd7;
   parameter logic [3:0] LEN_BYTES  = 4'd4;
   parameter logic [3:0] ADDR_BYTES = 4'd8;
   parameter logic [3:0] MAX_WORDS  = 4'd8;

   typedef enum logic [1:0] {
      REQ_TICK  = 2'd0,
      REQ_BYTE  = 2'd1,
      REQ_RDATA = 2'd2
   } req_kind_type;

   typedef enum logic [1:0] {
      KIND_TX    = 2'd0,
      KIND_WRITE = 2'd1,
      KIND_READ  = 2'd2,
      KIND_JUMP  = 2'd3
   } kind_type;

   typedef enum logic [2:0] {
      PH_IDLE = 3'd0,
      PH_LEN  = 3'd1,
      PH_ADDR = 3'd2,
      PH_DATA = 3'd3,
      PH_SKIP = 3'd4
   } phase_type;

   typedef enum logic [1:0] {
      CC_WRITE = 2'd0,
      CC_READ  = 2'd1,
      CC_JUMP  = 2'd2
   } cmd_type;

   typedef enum logic [1:0] {
      SIZE_BYTE = 2'd0,
      SIZE_WORD = 2'd1,
      SIZE_DWORD = 2'd2
   } size_type;

   typedef struct packed {
      kind_type    kind;
      logic [7:0]  tx;
      logic [63:0] addr;
      size_type    size;
      logic [63:0] wdata;
   } rec_type;

   // results of one input word: either up to two records, or a run of
   // transmit bytes taken from a read data word, low byte first
   typedef struct packed {
      logic [3:0]  cnt;
      logic        data_mode;
      logic [63:0] data;
      rec_type     rec0;
      rec_type     rec1;
   } burst_type;

   function automatic logic word_len(input logic [31:0] len);
      return (len == 32'd1) || (len == 32'd4) || (len == 32'd8);
   endfunction

   function automatic size_type size_code(input logic [31:0] len);
      size_type s;
      if (len == 32'd8) begin
         s = SIZE_DWORD;
      end else if (len == 32'd4) begin
         s = SIZE_WORD;
      end else begin
         s = SIZE_BYTE;
      end
      return s;
   endfunction

   function automatic rec_type mk_rec(input kind_type kind, input logic [7:0] tx,
                                      input logic [63:0] addr, input size_type size,
                                      input logic [63:0] wdata);
      rec_type r;
      r.kind  = kind;
      r.tx    = tx;
      r.addr  = addr;
      r.size  = size;
      r.wdata = wdata;
      return r;
   endfunction

   function automatic rec_type mk_tx(input logic [7:0] tx);
      return mk_rec(KIND_TX, tx, 64'd0, SIZE_BYTE, 64'd0);
   endfunction

endpackage

/* hdl/umdb_req_if.sv */
// request channel of the debug bridge: valid/ready plus one request word
// no dependencies
interface umdb_req_if;
   logic        valid;
   logic        ready;
   logic [1:0]  req_type;
   logic [7:0]  rx_byte;
   logic [63:0] read_data;

   modport source (output valid, output req_type, output rx_byte, output read_data,
                   input ready);
   modport sink (input valid, input req_type, input rx_byte, input read_data,
                 output ready);
endinterface

/* hdl/umdb_rsp_if.sv */
// result channel of the debug bridge: valid/ready plus one result word
// no dependencies
interface umdb_rsp_if;
   logic        valid;
   logic        ready;
   logic [1:0]  out_kind;
   logic [7:0]  tx_byte;
   logic [63:0] mem_addr;
   logic [1:0]  mem_size;
   logic [63:0] mem_wdata;
   logic        last;

   modport source (output valid, output out_kind, output tx_byte, output mem_addr,
                   output mem_size, output mem_wdata, output last, input ready);
   modport sink (input valid, input out_kind, input tx_byte, input mem_addr,
                 input mem_size, input mem_wdata, input last, output ready);
endinterface

/* hdl/umdb_parser.sv */
// unlock matcher and command parser; turns one request word into a burst
// depends on umdb_pkg and uart_memory_debug_bridge_macros.svh
`include "uart_memory_debug_bridge_macros.svh"

module umdb_parser (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 take,
   input  logic [1:0]           req_type,
   input  logic [7:0]           rx_byte,
   input  logic [63:0]          read_data,
   output umdb_pkg::burst_type  burst
);

   logic                 unlocked_ff, unlocked_in;
   logic [63:0]          match_ff, match_in;
   umdb_pkg::phase_type  phase_ff, phase_in;
   umdb_pkg::cmd_type    cmd_ff, cmd_in;
   logic [3:0]           hcount_ff, hcount_in;
   logic [31:0]          tlen_ff, tlen_in;
   logic [63:0]          taddr_ff, taddr_in;
   logic [63:0]          accum_ff, accum_in;
   logic [31:0]          remain_ff, remain_in;
   logic                 pending_ff, pending_in;

   logic [63:0] shift_word;
   logic [3:0]  hcount_inc;
   logic [63:0] addr_shift;
   logic [63:0] accum_shift;
   logic [31:0] remain_dec;
   logic [31:0] wr_off;
   logic [63:0] wr_addr;
   logic [31:0] rd_remain;
   logic [31:0] rd_off;
   logic [63:0] rd_addr;

   assign shift_word  = {match_ff[55:0], rx_byte};
   assign hcount_inc  = hcount_ff + 4'd1;
   assign addr_shift  = {taddr_ff[55:0], rx_byte};
   assign accum_shift = {accum_ff[55:0], rx_byte};
   assign remain_dec  = remain_ff - 32'd1;
   assign wr_off      = tlen_ff - remain_ff;
   assign wr_addr     = taddr_ff + {32'd0, wr_off};
   // byte-at-a-time read: next offset after this returned byte
   assign rd_remain   = (remain_ff != 32'd0) ? remain_dec : 32'd0;
   assign rd_off      = tlen_ff - rd_remain;
   assign rd_addr     = taddr_ff + {32'd0, rd_off};

   always_comb begin
      unlocked_in = unlocked_ff;
      match_in    = match_ff;
      phase_in    = phase_ff;
      cmd_in      = cmd_ff;
      hcount_in   = hcount_ff;
      tlen_in     = tlen_ff;
      taddr_in    = taddr_ff;
      accum_in    = accum_ff;
      remain_in   = remain_ff;
      pending_in  = pending_ff;

      burst.cnt       = 4'd0;
      burst.data_mode = 1'b0;
      burst.data      = 64'd0;
      burst.rec0      = umdb_pkg::mk_tx(8'd0);
      burst.rec1      = umdb_pkg::mk_tx(8'd0);

      if (take) begin
         if (!unlocked_ff) begin
            if (req_type == umdb_pkg::REQ_TICK) begin
               burst.rec0 = umdb_pkg::mk_tx(umdb_pkg::CHAR_A);
               burst.cnt  = 4'd1;
            end else if (req_type == umdb_pkg::REQ_BYTE) begin
               match_in   = shift_word;
               burst.rec0 = umdb_pkg::mk_tx(rx_byte);
               burst.cnt  = 4'd1;
               if (shift_word == umdb_pkg::MAGIC_WORD) begin
                  burst.rec1  = umdb_pkg::mk_tx(umdb_pkg::CHAR_Y);
                  burst.cnt   = 4'd2;
                  unlocked_in = 1'b1;
                  phase_in    = umdb_pkg::PH_IDLE;
                  hcount_in   = 4'd0;
                  pending_in  = 1'b0;
               end
            end
         end else if (req_type == umdb_pkg::REQ_BYTE && !pending_ff) begin
            case (phase_ff)
               umdb_pkg::PH_LEN: begin
                  tlen_in   = {tlen_ff[23:0], rx_byte};
                  hcount_in = hcount_inc;
                  if (hcount_inc >= umdb_pkg::LEN_BYTES) begin
                     hcount_in = 4'd0;
                     phase_in  = umdb_pkg::PH_ADDR;
                  end
               end
               umdb_pkg::PH_ADDR: begin
                  taddr_in  = addr_shift;
                  hcount_in = hcount_inc;
                  if (hcount_inc >= umdb_pkg::ADDR_BYTES) begin
                     hcount_in = 4'd0;
                     phase_in  = umdb_pkg::PH_IDLE;
                     case (cmd_ff)
                        umdb_pkg::CC_WRITE: begin
                           if (tlen_ff == 32'd0) begin
                              burst.rec0 = umdb_pkg::mk_tx(umdb_pkg::CHAR_Y);
                              burst.cnt  = 4'd1;
                           end else begin
                              accum_in  = 64'd0;
                              remain_in = tlen_ff;
                              phase_in  = umdb_pkg::PH_DATA;
                           end
                        end
                        umdb_pkg::CC_READ: begin
                           if (tlen_ff != 32'd0) begin
                              remain_in  = tlen_ff;
                              pending_in = 1'b1;
                              burst.rec0 = umdb_pkg::mk_rec(umdb_pkg::KIND_READ, 8'd0,
                                 addr_shift, umdb_pkg::size_code(tlen_ff), 64'd0);
                              burst.cnt  = 4'd1;
                           end
                        end
                        umdb_pkg::CC_JUMP: begin
                           burst.rec0 = umdb_pkg::mk_tx(umdb_pkg::CHAR_Y);
                           burst.rec1 = umdb_pkg::mk_rec(umdb_pkg::KIND_JUMP, 8'd0,
                              addr_shift, umdb_pkg::SIZE_BYTE, 64'd0);
                           burst.cnt  = 4'd2;
                        end
                        default: begin
                           // unknown command code: back to idle silently
                        end
                     endcase
                  end
               end
               umdb_pkg::PH_DATA: begin
                  remain_in = remain_dec;
                  if (umdb_pkg::word_len(tlen_ff)) begin
                     accum_in = accum_shift;
                     if (remain_dec == 32'd0) begin
                        burst.rec0 = umdb_pkg::mk_rec(umdb_pkg::KIND_WRITE, 8'd0, taddr_ff,
                           umdb_pkg::size_code(tlen_ff), accum_shift);
                        burst.rec1 = umdb_pkg::mk_tx(umdb_pkg::CHAR_Y);
                        burst.cnt  = 4'd2;
                        phase_in   = umdb_pkg::PH_IDLE;
                     end
                  end else begin
                     burst.rec0 = umdb_pkg::mk_rec(umdb_pkg::KIND_WRITE, 8'd0, wr_addr,
                        umdb_pkg::SIZE_BYTE, {56'd0, rx_byte});
                     burst.cnt  = 4'd1;
                     if (remain_dec == 32'd0) begin
                        burst.rec1 = umdb_pkg::mk_tx(umdb_pkg::CHAR_Y);
                        burst.cnt  = 4'd2;
                        phase_in   = umdb_pkg::PH_IDLE;
                     end
                  end
               end
               umdb_pkg::PH_SKIP: begin
                  hcount_in = hcount_inc;
                  if (hcount_inc >= umdb_pkg::SKIP_BYTES) begin
                     hcount_in  = 4'd0;
                     phase_in   = umdb_pkg::PH_IDLE;
                     burst.rec0 = umdb_pkg::mk_tx(umdb_pkg::CHAR_Y);
                     burst.cnt  = 4'd1;
                  end
               end
               default: begin
                  // idle, and any stray phase code, waits for a command byte
                  phase_in  = umdb_pkg::PH_IDLE;
                  hcount_in = 4'd0;
                  if (rx_byte == umdb_pkg::CHAR_W || rx_byte == umdb_pkg::CHAR_R) begin
                     cmd_in   = (rx_byte == umdb_pkg::CHAR_W) ? umdb_pkg::CC_WRITE
                                                              : umdb_pkg::CC_READ;
                     tlen_in  = 32'd0;
                     taddr_in = 64'd0;
                     phase_in = umdb_pkg::PH_LEN;
                  end else if (rx_byte == umdb_pkg::CHAR_J) begin
                     cmd_in   = umdb_pkg::CC_JUMP;
                     taddr_in = 64'd0;
                     phase_in = umdb_pkg::PH_ADDR;
                  end else if (rx_byte == umdb_pkg::CHAR_G) begin
                     phase_in = umdb_pkg::PH_SKIP;
                  end else begin
                     burst.rec0 = umdb_pkg::mk_tx(umdb_pkg::CHAR_N);
                     burst.cnt  = 4'd1;
                  end
               end
            endcase
         end else if (req_type == umdb_pkg::REQ_RDATA && pending_ff) begin
            if (umdb_pkg::word_len(tlen_ff)) begin
               burst.data_mode = 1'b1;
               burst.data      = read_data;
               burst.cnt       = tlen_ff[3:0];
               remain_in       = 32'd0;
               pending_in      = 1'b0;
            end else begin
               burst.rec0 = umdb_pkg::mk_tx(read_data[7:0]);
               burst.cnt  = 4'd1;
               remain_in  = rd_remain;
               if (rd_remain == 32'd0) begin
                  pending_in = 1'b0;
               end else begin
                  burst.rec1 = umdb_pkg::mk_rec(umdb_pkg::KIND_READ, 8'd0, rd_addr,
                     umdb_pkg::SIZE_BYTE, 64'd0);
                  burst.cnt  = 4'd2;
               end
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         unlocked_ff <= 1'b0;
         match_ff    <= 64'd0;
         phase_ff    <= umdb_pkg::PH_IDLE;
         cmd_ff      <= umdb_pkg::CC_WRITE;
         hcount_ff   <= 4'd0;
         tlen_ff     <= 32'd0;
         taddr_ff    <= 64'd0;
         accum_ff    <= 64'd0;
         remain_ff   <= 32'd0;
         pending_ff  <= 1'b0;
      end else begin
         unlocked_ff <= unlocked_in;
         match_ff    <= match_in;
         phase_ff    <= phase_in;
         cmd_ff      <= cmd_in;
         hcount_ff   <= hcount_in;
         tlen_ff     <= tlen_in;
         taddr_ff    <= taddr_in;
         accum_ff    <= accum_in;
         remain_ff   <= remain_in;
         pending_ff  <= pending_in;
      end
   end

   `UMDB_ASSERT_NEXT(a_unlock_sticks, unlocked_ff, unlocked_ff, "bridge relocked")
   `UMDB_ASSERT_IMPLY(a_pending_idle, pending_ff, phase_ff == umdb_pkg::PH_IDLE, "read pending outside idle")
   `UMDB_ASSERT_IMPLY(a_burst_len, burst.data_mode, burst.cnt == 4'd1 || burst.cnt == 4'd4 || burst.cnt == 4'd8, "bad read burst length")
   `UMDB_ASSERT_IMPLY(a_data_remain, phase_ff == umdb_pkg::PH_DATA, remain_ff != 32'd0, "data phase with nothing left")

endmodule

/* hdl/umdb_out_seq.sv */
// result register: holds one burst and hands it out one word per cycle while rsp is ready
// depends on umdb_pkg, umdb_rsp_if and uart_memory_debug_bridge_macros.svh
`include "uart_memory_debug_bridge_macros.svh"

module umdb_out_seq (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 load,
   input  umdb_pkg::burst_type  burst_in,
   output logic                 free,
   umdb_rsp_if.source           rsp
);

   logic [3:0]         cnt_ff, cnt_in;
   logic               mode_ff, mode_in;
   logic [63:0]        data_ff, data_in;
   umdb_pkg::rec_type  rec0_ff, rec0_in;
   umdb_pkg::rec_type  rec1_ff, rec1_in;
   umdb_pkg::rec_type  cur;
   logic               fire;

   assign fire = rsp.valid && rsp.ready;
   // a new burst may enter while the final word of the previous one leaves
   assign free = (cnt_ff == 4'd0) || (cnt_ff == 4'd1 && rsp.ready);

   assign cur = mode_ff ? umdb_pkg::mk_tx(data_ff[7:0]) : rec0_ff;

   assign rsp.valid     = (cnt_ff != 4'd0);
   assign rsp.out_kind  = cur.kind;
   assign rsp.tx_byte   = cur.tx;
   assign rsp.mem_addr  = cur.addr;
   assign rsp.mem_size  = cur.size;
   assign rsp.mem_wdata = cur.wdata;
   assign rsp.last      = (cnt_ff == 4'd1);

   always_comb begin
      cnt_in  = cnt_ff;
      mode_in = mode_ff;
      data_in = data_ff;
      rec0_in = rec0_ff;
      rec1_in = rec1_ff;
      if (load) begin
         cnt_in  = burst_in.cnt;
         mode_in = burst_in.data_mode;
         data_in = burst_in.data;
         rec0_in = burst_in.rec0;
         rec1_in = burst_in.rec1;
      end else if (fire) begin
         cnt_in  = cnt_ff - 4'd1;
         data_in = {8'd0, data_ff[63:8]};
         rec0_in = rec1_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= 4'd0;
      end else begin
         cnt_ff <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      mode_ff <= mode_in;
      data_ff <= data_in;
      rec0_ff <= rec0_in;
      rec1_ff <= rec1_in;
   end

   `UMDB_ASSERT_ALWAYS(a_cnt_range, cnt_ff <= umdb_pkg::MAX_WORDS, "burst count out of range")
   `UMDB_ASSERT_NEXT(a_burst_continues, fire && !load && cnt_ff > 4'd1, rsp.valid, "burst cut short")
   `UMDB_ASSERT_IMPLY(a_load_free, load, free, "burst loaded over pending words")

endmodule

/* hdl/uart_memory_debug_bridge.sv */
// serial debug bridge: first result in the cycle after a word is accepted
// throughput: one request word per cycle while rsp_ch is ready and each word
// yields at most one result; a word with n results (n up to 8) holds the result
// register until all leave; the next word is taken in the cycle the last one leaves
// reset is synchronous: bridge locked, parser idle, result register empty
// depends on umdb_pkg, umdb_req_if, umdb_rsp_if, umdb_parser, umdb_out_seq
module uart_memory_debug_bridge (
   input  logic        clock,
   input  logic        reset,
   umdb_req_if.sink    req_ch,
   umdb_rsp_if.source  rsp_ch
);

   logic                 free;
   logic                 take;
   umdb_pkg::burst_type  burst;

   assign req_ch.ready = free;
   assign take         = req_ch.valid && free;

   umdb_parser u_parser (
      .clock     (clock),
      .reset     (reset),
      .take      (take),
      .req_type  (req_ch.req_type),
      .rx_byte   (req_ch.rx_byte),
      .read_data (req_ch.read_data),
      .burst     (burst)
   );

   umdb_out_seq u_out_seq (
      .clock    (clock),
      .reset    (reset),
      .load     (take),
      .burst_in (burst),
      .free     (free),
      .rsp      (rsp_ch)
   );

endmodule
